// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside of reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== hdl/spf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spf_pkg;

    localparam int SAMPLE_FIELD_W = 32;
    localparam int POS_W          = 32;

    // One sample held in the input register.
    typedef struct packed {
        logic                      valid;
        logic [SAMPLE_FIELD_W-1:0] sample_value;
        logic                      run_end;
    } item_t;

endpackage

`default_nettype wire

// ===== hdl/spf_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface spf_sample_if;
    logic                               valid;
    logic                               ready;
    logic [spf_pkg::SAMPLE_FIELD_W-1:0] sample_value;
    logic                               run_end;

    modport source (output valid, output sample_value, output run_end, input ready);
    modport sink   (input valid, input sample_value, input run_end, output ready);
endinterface

interface spf_result_if;
    logic                             valid;
    logic                             ready;
    logic signed [spf_pkg::POS_W-1:0] peak_position;

    modport source (output valid, output peak_position, input ready);
    modport sink   (input valid, input peak_position, output ready);
endinterface

`default_nettype wire

// ===== hdl/spf_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module spf_in_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    spf_sample_if.sink          sample_in,
    input  wire logic           take,
    output spf_pkg::item_t      item
);

    logic                               valid_reg;
    logic                               valid_next;
    logic [spf_pkg::SAMPLE_FIELD_W-1:0] sample_reg;
    logic                               run_end_reg;
    logic                               accept;

    assign sample_in.ready = !valid_reg || take;
    assign accept          = sample_in.valid && sample_in.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg  <= sample_in.sample_value;
            run_end_reg <= sample_in.run_end;
        end
    end

    assign item.valid        = valid_reg;
    assign item.sample_value = sample_reg;
    assign item.run_end      = run_end_reg;

    // A held sample must not change until the tracker takes it.
    `ASSERT_PROP(a_hold_until_taken, clk, rst_n,
        valid_reg && !take |=> valid_reg && $stable(sample_reg) && $stable(run_end_reg),
        "input register changed before it was taken")

endmodule

`default_nettype wire

// ===== hdl/spf_track.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module spf_track #(
    parameter int SAMPLE_BITS    = 32,
    parameter int MAX_RUN_LENGTH = 65536
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire spf_pkg::item_t                   item,
    output logic                                  take,
    input  wire logic signed [spf_pkg::POS_W-1:0] start_position,
    spf_result_if.source                          result_out
);

    localparam int SW     = (SAMPLE_BITS < spf_pkg::SAMPLE_FIELD_W) ?
                            SAMPLE_BITS : spf_pkg::SAMPLE_FIELD_W;
    localparam int SUM_W  = SW + 2;
    localparam int CNT_RAW = $clog2(MAX_RUN_LENGTH + 1);
    localparam int CNT_W  = (CNT_RAW > 2) ? CNT_RAW : 2;

    logic [SW-1:0]    older_reg;
    logic [SW-1:0]    newer_reg;
    logic [CNT_W-1:0] seen_reg;
    logic [SUM_W-1:0] best_sum_reg;
    logic [CNT_W-1:0] best_off_reg;

    logic [SUM_W-1:0] best_sum_next;
    logic [CNT_W-1:0] best_off_next;
    logic [CNT_W-1:0] offset;

    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic signed [spf_pkg::POS_W-1:0] peak_reg;

    logic [SW-1:0]    v;
    logic [CNT_W-1:0] k;
    logic             k_is1;
    logic             k_is2;
    logic             k_ge2;
    logic             last;
    logic             fire;
    logic [SUM_W-1:0] head_sum;
    logic [SUM_W-1:0] mid_sum;
    logic [SUM_W-1:0] tail_sum;

    always_comb
    begin
        v     = item.sample_value[SW-1:0];
        k     = seen_reg;
        k_is1 = (k == CNT_W'(1));
        k_is2 = (k == CNT_W'(2));
        k_ge2 = (k >= CNT_W'(2));
        // The longest allowed run ends on its final sample regardless of the flag.
        last  = item.run_end || (k == CNT_W'(MAX_RUN_LENGTH - 1));

        head_sum = (SUM_W'(newer_reg) << 1) + SUM_W'(v);
        mid_sum  = SUM_W'(older_reg) + SUM_W'(newer_reg) + SUM_W'(v);
        tail_sum = SUM_W'(newer_reg) + (SUM_W'(v) << 1);

        best_sum_next = best_sum_reg;
        best_off_next = best_off_reg;
        offset        = '0;

        if (k_is1)
        begin
            best_sum_next = head_sum;
            best_off_next = '0;
            if (tail_sum > head_sum)
            begin
                offset = CNT_W'(1);
            end
        end
        else if (k_ge2)
        begin
            if (mid_sum > best_sum_reg)
            begin
                best_sum_next = mid_sum;
                best_off_next = k - CNT_W'(1);
            end
            if (k_is2)
            begin
                // Three-sample run: compare the raw samples directly.
                if (older_reg > newer_reg && older_reg > v)
                begin
                    offset = '0;
                end
                else if (newer_reg > v)
                begin
                    offset = CNT_W'(1);
                end
                else
                begin
                    offset = CNT_W'(2);
                end
            end
            else if (tail_sum > best_sum_next)
            begin
                offset = k;
            end
            else
            begin
                offset = best_off_next;
            end
        end
    end

    // A sample that ends a run waits while an earlier result is still unread.
    assign fire = item.valid && (!last || !out_valid_reg || result_out.ready);
    assign take = fire;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire && last)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            older_reg     <= '0;
            newer_reg     <= '0;
            seen_reg      <= '0;
            best_sum_reg  <= '0;
            best_off_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                if (last)
                begin
                    older_reg    <= '0;
                    newer_reg    <= '0;
                    seen_reg     <= '0;
                    best_sum_reg <= '0;
                    best_off_reg <= '0;
                end
                else
                begin
                    older_reg    <= newer_reg;
                    newer_reg    <= v;
                    seen_reg     <= k + CNT_W'(1);
                    best_sum_reg <= best_sum_next;
                    best_off_reg <= best_off_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && last)
        begin
            peak_reg <= start_position + spf_pkg::POS_W'(offset);
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.peak_position = peak_reg;

    `ASSERT_NEVER(a_seen_in_range, clk, rst_n,
        seen_reg > CNT_W'(MAX_RUN_LENGTH - 1),
        "sample count passed the longest run")

    `ASSERT_PROP(a_run_cleared, clk, rst_n,
        fire && last |=> seen_reg == '0 && best_sum_reg == '0,
        "run state not cleared after a result")

    `ASSERT_PROP(a_result_has_cause, clk, rst_n,
        !out_valid_reg ##1 out_valid_reg |-> $past(fire && last),
        "result appeared without a closing sample")

    `ASSERT_PROP(a_best_behind_count, clk, rst_n,
        best_off_reg < seen_reg || (seen_reg == '0 && best_off_reg == '0),
        "best position lies beyond the samples seen")

endmodule

`default_nettype wire

// ===== hdl/smoothed_peak_position_finder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Smoothed peak position finder. Samples of a run arrive one transaction at a
// time on sample_in, with run_end set on the last one. For every position the
// block forms the sum of the sample and its two neighbors (the edge sample
// counts twice at either end of the run), keeps the largest sum with the
// earliest position winning ties, and on the last sample sends one
// transaction on result_out: start_position plus the offset of that peak,
// wrapping at 32 bits. A run of one sample returns start_position; a run of
// exactly three picks its position by direct strict comparison of the raw
// samples. A run is closed by force on its MAX_RUN_LENGTH-th sample. Only the
// low SAMPLE_BITS bits of each sample are used; sums carry two extra bits so
// they never wrap. The block takes one sample per clock cycle without gaps
// but while an earlier result is unread a closing sample waits. A closing
// sample lands in the input register; once taken, the add-compare of the
// sums and the start-plus-offset add load the result register, which
// is the critical path. While a result waits unread, samples that do
// not close a run keep flowing. Write start_position through cfg_we and
// cfg_wdata only while no run is in progress; it is read when a result forms.

module smoothed_peak_position_finder #(
    parameter int SAMPLE_BITS    = 32,
    parameter int MAX_RUN_LENGTH = 65536
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    spf_sample_if.sink                            sample_in,
    spf_result_if.source                          result_out,
    input  wire logic                             cfg_we,
    input  wire logic signed [spf_pkg::POS_W-1:0] cfg_wdata
);

    logic signed [spf_pkg::POS_W-1:0] start_reg;
    spf_pkg::item_t                   item;
    logic                             take;

    // Hold the run start position; reset puts it at zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
        end
        else if (cfg_we)
        begin
            start_reg <= cfg_wdata;
        end
    end

    // Register each accepted sample before it meets the run state.
    spf_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (sample_in),
        .take      (take),
        .item      (item)
    );

    // Advance the run state and drive the result register.
    spf_track #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .MAX_RUN_LENGTH (MAX_RUN_LENGTH)
    ) u_track (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item),
        .take           (take),
        .start_position (start_reg),
        .result_out     (result_out)
    );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for smoothed_peak_position_finder.
// Sends runs of samples on sample_in and predicts each peak position in a
// local model of the three-point smoothing and argmax. Every result seen on
// result_out is checked against the oldest prediction. Both sides idle at
// random, with occasional stretches of back-to-back traffic.
module tb_top;

    localparam int  RUN_MAX      = 65536;
    localparam int  RANDOM_ITEMS = 400;
    localparam int  SETTLE       = 4;        // idle clocks after the last predicted peak comes out
    localparam int  DRAIN        = 10;
    localparam int  CYCLE_LIMIT  = 2000000;

    typedef enum int {STYLE_FULL, STYLE_TIES, STYLE_TOP, STYLE_RAILS} value_style_e;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic signed [spf_pkg::POS_W-1:0] cfg_wdata;

    spf_sample_if sample_bus ();
    spf_result_if result_bus ();

    smoothed_peak_position_finder #(
        .SAMPLE_BITS    (32),
        .MAX_RUN_LENGTH (RUN_MAX)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_bus),
        .result_out (result_bus),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata)
    );

    // Local copy of the block state.
    logic [spf_pkg::POS_W-1:0] start_pos;
    logic [31:0] prev2_sample;
    logic [31:0] prev1_sample;
    logic [16:0] run_count;
    logic [33:0] peak_sum;
    logic [15:0] peak_offset;

    logic [spf_pkg::POS_W-1:0] expected_peaks[$];

    int  cycle_count;
    int  fail_count;
    int  samples_sent;
    int  peaks_checked;
    int  runs_sent;
    int  starts_written;
    bit  no_idle;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d peaks still expected",
                     $time, cycle_count, expected_peaks.size());
            $display("status: fail");
            $finish;
        end
    end

    // Advance the model by one sample; return 1 with the peak position when the
    // sample closes a run.
    function automatic bit predict_peak(input logic [31:0] value, input logic close_flag,
                                        output logic [spf_pkg::POS_W-1:0] position);
        logic [16:0] k;
        logic [15:0] offset;
        logic [33:0] mid_sum;
        logic [33:0] tail_sum;
        bit          closing;
        k        = run_count;
        offset   = '0;
        closing  = close_flag;
        position = '0;
        tail_sum = {2'b00, prev1_sample} + {2'b00, value} + {2'b00, value};
        if (int'(k) + 1 >= RUN_MAX)
            closing = 1'b1;
        if (k == 17'd1)
        begin
            peak_sum    = {2'b00, prev1_sample} + {2'b00, prev1_sample} + {2'b00, value};
            peak_offset = '0;
            if (closing && tail_sum > peak_sum)
                offset = 16'd1;
        end
        else if (k >= 17'd2)
        begin
            mid_sum = {2'b00, prev2_sample} + {2'b00, prev1_sample} + {2'b00, value};
            if (mid_sum > peak_sum)
            begin
                peak_sum    = mid_sum;
                peak_offset = 16'(k - 17'd1);
            end
            if (closing)
            begin
                if (k == 17'd2)
                begin
                    // Three samples: plain strict comparison, no sums.
                    if (prev2_sample > prev1_sample && prev2_sample > value)
                        offset = 16'd0;
                    else if (prev1_sample > value)
                        offset = 16'd1;
                    else
                        offset = 16'd2;
                end
                else
                begin
                    offset = peak_offset;
                    if (tail_sum > peak_sum)
                        offset = 16'(k);
                end
            end
        end
        if (closing)
        begin
            position     = start_pos + {16'd0, offset};
            prev2_sample = '0;
            prev1_sample = '0;
            run_count    = '0;
            peak_sum     = '0;
            peak_offset  = '0;
            return 1'b1;
        end
        prev2_sample = prev1_sample;
        prev1_sample = value;
        run_count    = k + 17'd1;
        return 1'b0;
    endfunction

    // Send one sample transaction and record its prediction on acceptance.
    task automatic send_sample(input logic [31:0] value, input logic close_flag);
        int gap;
        logic [spf_pkg::POS_W-1:0] position;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_bus.valid        <= 1'b1;
        sample_bus.sample_value <= value;
        sample_bus.run_end      <= close_flag;
        @(posedge clk);
        while (!sample_bus.ready)
            @(posedge clk);
        samples_sent++;
        if (predict_peak(value, close_flag, position))
        begin
            expected_peaks.push_back(position);
            runs_sent++;
        end
    endtask

    task automatic send_run(input logic [31:0] values[$]);
        foreach (values[i])
            send_sample(values[i], i == values.size() - 1);
    endtask

    // Drop valid and hold until every predicted peak has come out.
    task automatic wait_for_idle();
        sample_bus.valid <= 1'b0;
        while (expected_peaks.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_start(input logic [spf_pkg::POS_W-1:0] value);
        wait_for_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        start_pos = value;
        starts_written++;
    endtask

    function automatic logic [31:0] draw_sample(input value_style_e style);
        case (style)
            STYLE_TIES:  return 32'($urandom_range(0, 3));
            STYLE_TOP:   return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
            STYLE_RAILS: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default:     return $urandom;
        endcase
    endfunction

    function automatic logic [spf_pkg::POS_W-1:0] draw_start();
        case ($urandom_range(0, 4))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Start stays at its reset value of zero here.
    task automatic test_single_sample_runs();
        send_run('{32'h0});
        send_run('{32'hFFFF_FFFF});
    endtask

    task automatic test_two_sample_runs();
        send_run('{32'd7, 32'd7});                    // tie keeps offset 0
        send_run('{32'd5, 32'd6});                    // later sample strictly wins
        send_run('{32'hFFFF_FFFF, 32'hFFFF_FFFE});
    endtask

    task automatic test_three_sample_runs();
        send_run('{32'd9, 32'd3, 32'd8});             // first beats both
        send_run('{32'd4, 32'd4, 32'd1});             // tie on first, middle wins
        send_run('{32'd2, 32'd2, 32'd2});             // all equal, last wins
    endtask

    // Sums of full-scale samples need the two extra bits.
    task automatic test_wide_sums();
        send_run('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF});
    endtask

    task automatic test_start_extremes();
        write_start(32'h7FFF_FFFF);                   // offset wraps past the top
        send_run('{32'd1, 32'd2, 32'd3, 32'd9});
        write_start(32'h8000_0000);
        send_run('{32'd1, 32'd8, 32'd2, 32'd0});
        write_start(32'hFFFF_FFFF);
        send_run('{32'd0, 32'd0, 32'd5});
    endtask

    task automatic test_random_runs();
        int start_count;
        int len;
        value_style_e style;
        start_count = samples_sent;
        while (samples_sent - start_count < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
                write_start(draw_start());
            no_idle = ($urandom_range(0, 5) == 0);
            len = ($urandom_range(0, 9) < 4) ? $urandom_range(1, 3) : $urandom_range(4, 16);
            style = value_style_e'($urandom_range(0, 3));
            for (int i = 0; i < len; i++)
                send_sample(draw_sample(style), i == len - 1);
        end
        no_idle = 1'b0;
    endtask

    // Result side: draw a stall per transaction and check each peak.
    initial
    begin
        int gap;
        logic [spf_pkg::POS_W-1:0] wanted;
        result_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            @(posedge clk);
            while (!result_bus.valid)
                @(posedge clk);
            if (expected_peaks.size() == 0)
            begin
                $display("%0t: unexpected peak_position, expected none, actual %0d",
                         $time, result_bus.peak_position);
                fail_count++;
            end
            else
            begin
                wanted = expected_peaks.pop_front();
                peaks_checked++;
                if (result_bus.peak_position !== wanted)
                begin
                    $display("%0t: peak_position mismatch, expected %0d, actual %0d",
                             $time, $signed(wanted), result_bus.peak_position);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n                   <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_wdata               <= '0;
        sample_bus.valid        <= 1'b0;
        sample_bus.sample_value <= '0;
        sample_bus.run_end      <= 1'b0;
        cycle_count    = 0;
        fail_count     = 0;
        samples_sent   = 0;
        peaks_checked  = 0;
        runs_sent      = 0;
        starts_written = 0;
        no_idle        = 1'b0;
        start_pos      = '0;
        prev2_sample   = '0;
        prev1_sample   = '0;
        run_count      = '0;
        peak_sum       = '0;
        peak_offset    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_sample_runs();
        test_two_sample_runs();
        test_three_sample_runs();
        test_wide_sums();
        test_start_extremes();
        test_random_runs();

        wait_for_idle();
        repeat (DRAIN) @(posedge clk);

        $display("covered %0d samples in %0d runs, %0d peaks checked, %0d start writes",
                 samples_sent, runs_sent, peaks_checked, starts_written);
        $display("including runs of one to three samples, full-scale sums and start values at both extremes");
        if (fail_count == 0 && expected_peaks.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
